// File: src/b64d_pkg.sv
// shared types for the base64 stream decoder
// input and result transfer structs, group record passed from front to back
// no dependencies
package b64d_pkg;

    typedef struct packed {
        logic [7:0] text_char;
        logic       final_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_output;
        logic       error;
    } out_item_t;

    // one decoded group: up to three bytes, or a single error result
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  last_idx;
        logic        fin;
        logic        err;
    } grp_rec_t;

endpackage

// File: src/b64d_front.sv
// front part: accepts characters, keeps the current group, validates and decodes it
// emits one group record per completed or failed group
// depends on b64d_pkg
module b64d_front
    import b64d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t in_item,
    output logic     rec_push,
    output grp_rec_t rec
);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // returns {valid, sextet}
    function automatic logic [6:0] sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A)
            r = {1'b1, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A)
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B)
            r = {1'b1, 6'd62};
        else if (c == 8'h2F)
            r = {1'b1, 6'd63};
        return r;
    endfunction

    logic [7:0] held_reg [3];
    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic       failed_reg;
    logic       failed_next;
    logic       store;

    logic [6:0] sa;
    logic [6:0] sb;
    logic [6:0] sc;
    logic [6:0] sd;
    logic       fin;
    logic       all_ok;
    logic       one_byte;
    logic       two_byte;

    always_comb
    begin
        fin      = in_item.final_char;
        sa       = sextet(held_reg[0]);
        sb       = sextet(held_reg[1]);
        sc       = sextet(held_reg[2]);
        sd       = sextet(in_item.text_char);
        all_ok   = sa[6] && sb[6] && sc[6] && sd[6];
        one_byte = fin && sa[6] && sb[6] && held_reg[2] == PAD_CHAR
                   && in_item.text_char == PAD_CHAR;
        two_byte = fin && sa[6] && sb[6] && sc[6] && in_item.text_char == PAD_CHAR;

        pos_next     = pos_reg;
        failed_next  = failed_reg;
        store        = 1'b0;
        rec_push     = 1'b0;
        rec.word     = {sa[5:0], sb[5:0], sc[5:0], sd[5:0]};
        rec.last_idx = 2'd0;
        rec.fin      = fin;
        rec.err      = 1'b0;

        if (take)
        begin
            if (failed_reg)
            begin
                if (fin)
                begin
                    failed_next = 1'b0;
                    pos_next    = 2'd0;
                end
            end
            else if (pos_reg != 2'd3)
            begin
                if (!fin)
                begin
                    store    = 1'b1;
                    pos_next = pos_reg + 2'd1;
                end
                else
                begin
                    pos_next = 2'd0;
                    rec_push = 1'b1;
                    rec.err  = 1'b1;
                end
            end
            else
            begin
                pos_next = 2'd0;
                rec_push = 1'b1;
                if (all_ok)
                    rec.last_idx = 2'd2;
                else if (one_byte)
                    rec.last_idx = 2'd0;
                else if (two_byte)
                    rec.last_idx = 2'd1;
                else
                begin
                    rec.err     = 1'b1;
                    failed_next = !fin;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 2'd0;
            failed_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            held_reg[pos_reg] <= in_item.text_char;
    end

endmodule

// File: src/b64d_queue.sv
// short queue of group records between front and back
// depends on b64d_pkg
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  grp_rec_t wr_rec,
    output logic     q_full,
    input  logic     rd,
    output grp_rec_t rd_rec,
    output logic     q_empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    grp_rec_t            slot_reg [DEPTH];
    logic [ADDR_W-1:0]   wp_reg;
    logic [ADDR_W-1:0]   rp_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_rec  = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == ADDR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == ADDR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wr_rec;
    end

endmodule

// File: src/b64d_back.sv
// back part: splits group records into result bytes, one per cycle
// if its result output register is free; depends on b64d_pkg
module b64d_back
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  grp_rec_t  q_rec,
    input  logic      q_empty,
    output logic      q_rd,
    output out_item_t result_item,
    output logic      empty,
    input  logic      pop
);

    grp_rec_t   cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    out_item_t  out_reg;
    logic       out_valid_reg;

    logic       out_free;
    logic       emit;
    logic       last;
    logic       cur_done;
    out_item_t  nxt;

    always_comb
    begin
        out_free = !out_valid_reg || pop;
        emit     = out_free && cur_valid_reg;
        last     = cur_reg.err || (idx_reg == cur_reg.last_idx);
        cur_done = emit && last;
        q_rd     = (!cur_valid_reg || cur_done) && !q_empty;

        case (idx_reg)
            2'd0:    nxt.data_byte = cur_reg.word[23:16];
            2'd1:    nxt.data_byte = cur_reg.word[15:8];
            default: nxt.data_byte = cur_reg.word[7:0];
        endcase
        if (cur_reg.err)
            nxt.data_byte = 8'd0;
        nxt.error         = cur_reg.err;
        nxt.end_of_output = cur_reg.err || (cur_reg.fin && last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (q_rd)
                cur_valid_reg <= 1'b1;
            else if (cur_done)
                cur_valid_reg <= 1'b0;

            if (q_rd)
                idx_reg <= 2'd0;
            else if (emit)
                idx_reg <= idx_reg + 2'd1;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            cur_reg <= q_rec;
        if (emit)
            out_reg <= nxt;
    end

    assign result_item = out_reg;
    assign empty       = !out_valid_reg;

endmodule

// File: src/base64_stream_decoder.sv
// Streaming base64 decoder (standard alphabet). One character is taken per cycle while
// full is low; every fourth character closes a group that yields three bytes, or one or
// two bytes for a padded final group, or a single error result that ends the stream.
// Results leave at one byte per cycle from an output register while pop is high, so
// three bytes per four characters keeps full low at the full input rate; full rises
// only when the group queue between the decode front and the byte back end fills, which
// happens when pop is held low.
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  text_item,
    output logic      full,
    input  logic      pop,
    output out_item_t result_item,
    output logic      empty
);

    logic     take;
    logic     rec_push;
    grp_rec_t rec;
    logic     q_full;
    logic     q_rd;
    grp_rec_t q_rec;
    logic     q_empty;

    assign full = q_full;
    assign take = push && !q_full;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .in_item  (text_item),
        .rec_push (rec_push),
        .rec      (rec)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rec_push),
        .wr_rec  (rec),
        .q_full  (q_full),
        .rd      (q_rd),
        .rd_rec  (q_rec),
        .q_empty (q_empty)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_rec       (q_rec),
        .q_empty     (q_empty),
        .q_rd        (q_rd),
        .result_item (result_item),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
